// ===== hw/rtl/pct_pkg.sv =====
// ---------------------------------------------------------------------------
// pct_pkg: shared types and constants of the periodic callout timer
// Request and status codes, field widths and the default slot count.
// ---------------------------------------------------------------------------
package pct_pkg;

  // Field widths
  localparam int unsigned TimeW   = 32;
  localparam int unsigned SlotIdW = 4;
  localparam int unsigned ReqW    = 2;
  localparam int unsigned StatW   = 2;

  // Default slot count and the cap on fires per tick
  localparam int unsigned SlotsDefault = 16;
  localparam int unsigned MaxFires     = 16;

  typedef enum logic [ReqW-1:0] {
    REQ_TICK = 2'd0,
    REQ_ADD  = 2'd1,
    REQ_DEL  = 2'd2,
    REQ_SET  = 2'd3
  } req_type_e;

  typedef enum logic [StatW-1:0] {
    ST_OK           = 2'd0,
    ST_BAD_INTERVAL = 2'd1,
    ST_EXISTS       = 2'd2,
    ST_NOT_FOUND    = 2'd3
  } status_e;

endpackage

// ===== hw/rtl/pct_req_if.sv =====
// ---------------------------------------------------------------------------
// pct_req_if: request channel of the periodic callout timer
// Valid/ready channel carrying one request item.
// ---------------------------------------------------------------------------
interface pct_req_if
  import pct_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [ReqW-1:0]    req_type;
  logic [SlotIdW-1:0] slot_id;
  logic [TimeW-1:0]   interval;
  logic [TimeW-1:0]   new_time;

  modport source (output valid, output req_type, output slot_id, output interval,
                  output new_time, input ready);
  modport sink   (input valid, input req_type, input slot_id, input interval,
                  input new_time, output ready);
endinterface

// ===== hw/rtl/pct_rsp_if.sv =====
// ---------------------------------------------------------------------------
// pct_rsp_if: result channel of the periodic callout timer
// Valid/ready channel carrying one result item.
// ---------------------------------------------------------------------------
interface pct_rsp_if
  import pct_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [StatW-1:0]   status;
  logic               fired;
  logic [SlotIdW-1:0] fired_slot;
  logic [TimeW-1:0]   current_time;
  logic               last;

  modport source (output valid, output status, output fired, output fired_slot,
                  output current_time, output last, input ready);
  modport sink   (input valid, input status, input fired, input fired_slot,
                  input current_time, input last, output ready);
endinterface

// ===== hw/rtl/pct_ram.sv =====
// ---------------------------------------------------------------------------
// pct_ram: generic single-port-write, registered-read RAM
// One write and one read per cycle; read data held until the next read.
// ---------------------------------------------------------------------------
module pct_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/periodic_callout_timer.sv =====
// ---------------------------------------------------------------------------
// periodic_callout_timer: seconds counter with periodic callout slots
// Top level: request decode, slot sweep sequencer and result register.
// ---------------------------------------------------------------------------
// Usage
//   req_i carries one request item: tick, add slot, delete slot or set time.
//   rsp_o carries result items. Add, delete and set time give one result;
//   a tick gives one result per fired slot (ascending slot index) or a
//   single no-fire result. The final result of a request has last set.
// Sequencing
//   Add, delete and set time: the accepted request is latched; EXEC
//   registers its result once the output register is free, then idles.
//   Tick: EXEC steps the counter, then the slot sweep runs: each valid
//   slot takes a READ of the slot RAM and an EVAL through the shared adder
//   and comparator, an invalid slot is skipped in READ, and FLUSH
//   registers the final result once the output register is free.
//   One request is in work at a time; req_i.ready is high only while idle.
// Stalls
//   A result waits in the output register while rsp_o.ready is low; the
//   next request is still taken then. A tick sweep holds when a second
//   fire is found while the output register is still occupied.
// Reset
//   Counter cleared to zero, all slots invalid, output register empty.
//   Slot RAM needs no clearing: only valid slots are read.
// ---------------------------------------------------------------------------
module periodic_callout_timer
  import pct_pkg::*;
#(
  parameter int unsigned SLOTS = SlotsDefault
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  pct_req_if.sink   req_i,
  pct_rsp_if.source rsp_o
);

  localparam int unsigned IdxW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned FcW   = $clog2(MaxFires + 1);
  localparam int unsigned WordW = 2 * TimeW;
  localparam logic [IdxW-1:0] LastIdx  = IdxW'(SLOTS - 1);
  localparam logic [FcW-1:0]  LastFire = FcW'(MaxFires - 1);

  // Sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_EVAL  = 3'd3;
  localparam logic [2:0] S_FLUSH = 3'd4;

  logic [2:0]         state_q, state_d;
  logic [TimeW-1:0]   time_q, time_d;
  logic [SLOTS-1:0]   valid_q, valid_d;
  logic [IdxW-1:0]    idx_q, idx_d;
  logic [FcW-1:0]     fire_cnt_q, fire_cnt_d;
  logic               pend_valid_q, pend_valid_d;
  logic [IdxW-1:0]    pend_slot_q, pend_slot_d;

  // Latched request
  logic [ReqW-1:0]    rq_type_q;
  logic [SlotIdW-1:0] rq_id_q;
  logic [TimeW-1:0]   rq_ival_q;
  logic [TimeW-1:0]   rq_time_q;

  // Output register
  logic               ov_q;
  logic [StatW-1:0]   o_status_q;
  logic               o_fired_q;
  logic [SlotIdW-1:0] o_slot_q;
  logic [TimeW-1:0]   o_time_q;
  logic               o_last_q;

  // Push into output register
  logic               push;
  logic [StatW-1:0]   p_status;
  logic               p_fired;
  logic [IdxW-1:0]    p_slot;
  logic               p_last;
  logic [IdxW+SlotIdW-1:0] p_slot_ext;

  // Slot RAM port signals
  logic               ram_we, ram_re;
  logic [IdxW-1:0]    ram_waddr;
  logic [WordW-1:0]   ram_wdata, ram_rdata;
  logic [TimeW-1:0]   ram_ival, ram_exp;

  // Shared adder and comparator
  logic [TimeW-1:0]   add_opnd, sum;
  logic               due;

  logic               out_free, accept, id_ok, sweep_end;
  logic [IdxW-1:0]    id_idx;

  assign out_free  = !ov_q || rsp_o.ready;
  assign accept    = req_i.valid && req_i.ready;
  assign ram_ival  = ram_rdata[WordW-1:TimeW];
  assign ram_exp   = ram_rdata[TimeW-1:0];
  assign add_opnd  = (state_q == S_EVAL) ? ram_ival : rq_ival_q;
  assign sum       = time_q + add_opnd;
  assign due       = (ram_exp <= time_q);
  assign id_ok     = (int'(rq_id_q) < int'(SLOTS));
  assign id_idx    = IdxW'(rq_id_q);
  assign sweep_end = (idx_q == LastIdx) || (due && (fire_cnt_q == LastFire));

  // Sequencer
  always_comb begin
    state_d      = state_q;
    time_d       = time_q;
    valid_d      = valid_q;
    idx_d        = idx_q;
    fire_cnt_d   = fire_cnt_q;
    pend_valid_d = pend_valid_q;
    pend_slot_d  = pend_slot_q;
    push         = 1'b0;
    p_status     = ST_OK;
    p_fired      = 1'b0;
    p_slot       = '0;
    p_last       = 1'b1;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    ram_waddr    = idx_q;
    ram_wdata    = {ram_ival, sum};

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (rq_type_q == REQ_TICK) begin
          time_d       = time_q + TimeW'(1);
          idx_d        = '0;
          fire_cnt_d   = '0;
          pend_valid_d = 1'b0;
          state_d      = S_READ;
        end else if (out_free) begin
          push    = 1'b1;
          state_d = S_IDLE;
          unique case (rq_type_q)
            REQ_ADD: begin
              if (rq_ival_q == '0) begin
                p_status = ST_BAD_INTERVAL;
              end else if (!id_ok) begin
                p_status = ST_NOT_FOUND;
              end else if (valid_q[id_idx]) begin
                p_status = ST_EXISTS;
              end else begin
                valid_d[id_idx] = 1'b1;
                ram_we          = 1'b1;
                ram_waddr       = id_idx;
                ram_wdata       = {rq_ival_q, sum};
              end
            end
            REQ_DEL: begin
              if (id_ok && valid_q[id_idx]) begin
                valid_d[id_idx] = 1'b0;
              end else begin
                p_status = ST_NOT_FOUND;
              end
            end
            default: begin
              time_d = rq_time_q;
            end
          endcase
        end
      end
      S_READ: begin
        if (valid_q[idx_q]) begin
          ram_re  = 1'b1;
          state_d = S_EVAL;
        end else if (idx_q == LastIdx) begin
          state_d = S_FLUSH;
        end else begin
          idx_d = idx_q + IdxW'(1);
        end
      end
      S_EVAL: begin
        // Hold while a second fire waits on a full output register
        if (!(due && pend_valid_q && !out_free)) begin
          if (due) begin
            ram_we       = 1'b1;
            push         = pend_valid_q;
            p_fired      = 1'b1;
            p_slot       = pend_slot_q;
            p_last       = 1'b0;
            pend_valid_d = 1'b1;
            pend_slot_d  = idx_q;
            fire_cnt_d   = fire_cnt_q + FcW'(1);
          end
          if (sweep_end) begin
            state_d = S_FLUSH;
          end else begin
            idx_d   = idx_q + IdxW'(1);
            state_d = S_READ;
          end
        end
      end
      S_FLUSH: begin
        if (out_free) begin
          push         = 1'b1;
          p_fired      = pend_valid_q;
          p_slot       = pend_valid_q ? pend_slot_q : '0;
          pend_valid_d = 1'b0;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign req_i.ready = (state_q == S_IDLE);
  assign p_slot_ext  = {{SlotIdW{1'b0}}, p_slot};

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      time_q       <= '0;
      valid_q      <= '0;
      idx_q        <= '0;
      fire_cnt_q   <= '0;
      pend_valid_q <= 1'b0;
      ov_q         <= 1'b0;
    end else begin
      state_q      <= state_d;
      time_q       <= time_d;
      valid_q      <= valid_d;
      idx_q        <= idx_d;
      fire_cnt_q   <= fire_cnt_d;
      pend_valid_q <= pend_valid_d;
      if (push) begin
        ov_q <= 1'b1;
      end else if (rsp_o.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    pend_slot_q <= pend_slot_d;
    if (accept) begin
      rq_type_q <= req_i.req_type;
      rq_id_q   <= req_i.slot_id;
      rq_ival_q <= req_i.interval;
      rq_time_q <= req_i.new_time;
    end
    if (push) begin
      o_status_q <= p_status;
      o_fired_q  <= p_fired;
      o_slot_q   <= p_slot_ext[SlotIdW-1:0];
      o_time_q   <= time_d;
      o_last_q   <= p_last;
    end
  end

  assign rsp_o.valid        = ov_q;
  assign rsp_o.status       = o_status_q;
  assign rsp_o.fired        = o_fired_q;
  assign rsp_o.fired_slot   = o_slot_q;
  assign rsp_o.current_time = o_time_q;
  assign rsp_o.last         = o_last_q;

  // Slot RAM: {reload interval, next expiry} per slot
  pct_ram #(
    .Width (WordW),
    .Depth (SLOTS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  // Checks
  a_pend_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !pend_valid_q)
    else $error("pending fire left over while idle");

  a_fire_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_cnt_q <= FcW'(MaxFires))
    else $error("fire count beyond cap");

  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_EXEC))
    else $error("accepted item not executed");

  a_push_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> out_free)
    else $error("result pushed over an unread result");

  a_fire_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.fired) |-> (rsp_o.status == ST_OK))
    else $error("fire result with non-ok status");

endmodule

// ===== verif/pct_timer_checker.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// pct_timer_checker: result checker for the periodic callout timer
// Watches the request and result channels, keeps its own copy of the
// counter and slot table, predicts the results of every accepted request
// and compares each accepted result with the oldest prediction.
// ---------------------------------------------------------------------------
module pct_timer_checker
  import pct_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  pct_req_if          req_mon,
  pct_rsp_if          rsp_mon,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned result_count_o,
  output int unsigned fire_count_o
);

  typedef struct packed {
    status_e            status;
    logic               fired;
    logic [SlotIdW-1:0] slot;
    logic [TimeW-1:0]   now;
    logic               last;
  } timer_result_t;

  // Predicted timer state
  logic [TimeW-1:0] clock_q;
  logic             slot_on     [SlotsDefault];
  logic [TimeW-1:0] slot_period [SlotsDefault];
  logic [TimeW-1:0] slot_due    [SlotsDefault];

  // Results still owed by the block, oldest first
  timer_result_t due_results[$];

  // Apply one request to the predicted state and queue the results it causes
  function automatic void advance_timer(input req_type_e kind,
                                        input logic [SlotIdW-1:0] id,
                                        input logic [TimeW-1:0] ival,
                                        input logic [TimeW-1:0] ntime);
    timer_result_t r;
    int unsigned   nfire;
    int unsigned   i;
    r = '{status: ST_OK, fired: 1'b0, slot: '0, now: '0, last: 1'b1};
    nfire = 0;
    case (kind)
      REQ_TICK: begin
        clock_q = clock_q + 1'b1;
        // sweep in ascending slot order, capped per tick
        for (i = 0; i < SlotsDefault && nfire < MaxFires; i++) begin
          if (slot_on[i] && slot_due[i] <= clock_q) begin
            slot_due[i] = clock_q + slot_period[i];
            r.fired = 1'b1;
            r.slot  = SlotIdW'(i);
            r.last  = 1'b0;
            r.now   = clock_q;
            due_results.push_back(r);
            nfire++;
          end
        end
        if (nfire != 0) begin
          // mark the final fire of this tick
          r = due_results.pop_back();
          r.last = 1'b1;
          due_results.push_back(r);
          return;
        end
      end
      REQ_ADD: begin
        if (ival == '0) begin
          r.status = ST_BAD_INTERVAL;
        end else if (int'(id) >= SlotsDefault) begin
          r.status = ST_NOT_FOUND;
        end else if (slot_on[id]) begin
          r.status = ST_EXISTS;
        end else begin
          slot_on[id]     = 1'b1;
          slot_period[id] = ival;
          slot_due[id]    = clock_q + ival;
        end
      end
      REQ_DEL: begin
        if (int'(id) < SlotsDefault && slot_on[id]) begin
          slot_on[id] = 1'b0;
        end else begin
          r.status = ST_NOT_FOUND;
        end
      end
      default: begin
        clock_q = ntime;
      end
    endcase
    r.now = clock_q;
    due_results.push_back(r);
  endfunction

  // Compare each accepted result, then fold in any accepted request
  always @(posedge clk_i or negedge rst_ni) begin
    timer_result_t got;
    timer_result_t want;
    if (!rst_ni) begin
      clock_q = '0;
      for (int k = 0; k < SlotsDefault; k++) begin
        slot_on[k]     = 1'b0;
        slot_period[k] = '0;
        slot_due[k]    = '0;
      end
      due_results.delete();
      fail_count_o   = 0;
      result_count_o = 0;
      fire_count_o   = 0;
      pending_o      = 0;
    end else begin
      if (rsp_mon.valid && rsp_mon.ready) begin
        got.status = status_e'(rsp_mon.status);
        got.fired  = rsp_mon.fired;
        got.slot   = rsp_mon.fired_slot;
        got.now    = rsp_mon.current_time;
        got.last   = rsp_mon.last;
        result_count_o++;
        if (got.fired === 1'b1) fire_count_o++;
        if (due_results.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10)
            $display("%0t: unexpected result status=%0d fired=%0b slot=%0d time=%h last=%0b",
                     $realtime, got.status, got.fired, got.slot, got.now, got.last);
        end else begin
          want = due_results.pop_front();
          if (got !== want) begin
            fail_count_o++;
            if (fail_count_o <= 10) begin
              $display("%0t: result mismatch", $realtime);
              $display("  expected status=%0d fired=%0b slot=%0d time=%h last=%0b",
                       want.status, want.fired, want.slot, want.now, want.last);
              $display("  actual   status=%0d fired=%0b slot=%0d time=%h last=%0b",
                       got.status, got.fired, got.slot, got.now, got.last);
            end
          end
        end
      end
      if (req_mon.valid && req_mon.ready) begin
        advance_timer(req_type_e'(req_mon.req_type), req_mon.slot_id,
                      req_mon.interval, req_mon.new_time);
      end
      pending_o = due_results.size();
    end
  end

endmodule

// ===== verif/periodic_callout_timer_tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// periodic_callout_timer_tb: testbench top of the periodic callout timer
// Drives a directed request sequence and then random requests under four
// mixes of sender gaps and receiver stalls; the checker beside the block
// predicts and compares every result, and this top gives the verdict.
// ---------------------------------------------------------------------------
module periodic_callout_timer_tb;
  import pct_pkg::*;

  logic clk_i;
  logic rst_ni;

  pct_req_if req_ch ();
  pct_rsp_if rsp_ch ();

  int unsigned fail_count;
  int unsigned pending;
  int unsigned result_count;
  int unsigned fire_count;

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned items_sent;

  // Idle mixes per random phase: none, sender idle, receiver stall, both
  int unsigned send_idle_tab  [4] = '{0, 70, 0, 14};
  int unsigned recv_stall_tab [4] = '{0, 0, 70, 14};

  periodic_callout_timer #(
    .SLOTS (SlotsDefault)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_ch),
    .rsp_o  (rsp_ch)
  );

  pct_timer_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_mon        (req_ch),
    .rsp_mon        (rsp_ch),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .result_count_o (result_count),
    .fire_count_o   (fire_count)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Receiver: stall at random per the current phase
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Hard stop if the block hangs
  initial begin
    #8_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // Offer one item and hold it until it is accepted
  task automatic send_request(input req_type_e kind, input logic [SlotIdW-1:0] id,
                              input logic [TimeW-1:0] ival,
                              input logic [TimeW-1:0] ntime);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_ch.valid    <= 1'b1;
    req_ch.req_type <= kind;
    req_ch.slot_id  <= id;
    req_ch.interval <= ival;
    req_ch.new_time <= ntime;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
    items_sent++;
    @(negedge clk_i);
  endtask

  // Pick one random request, weighted towards ticks and short intervals
  task automatic random_request();
    int unsigned pick;
    int unsigned r;
    logic [TimeW-1:0] ival;
    logic [TimeW-1:0] ntime;
    pick  = $urandom_range(99);
    r     = $urandom_range(99);
    ival  = $urandom;
    ntime = $urandom;
    if (pick < 45) begin
      send_request(REQ_TICK, SlotIdW'($urandom), $urandom, $urandom);
    end else if (pick < 75) begin
      if (r < 6)       ival = '0;
      else if (r < 80) ival = $urandom_range(1, 12);
      else if (r < 90) ival = $urandom_range(13, 300);
      send_request(REQ_ADD, SlotIdW'($urandom_range(15)), ival, $urandom);
    end else if (pick < 88) begin
      send_request(REQ_DEL, SlotIdW'($urandom_range(15)), $urandom, $urandom);
    end else begin
      // land near the wrap or near zero now and then
      if (r < 40)      ntime = 32'hFFFF_FFFF - $urandom_range(0, 20);
      else if (r < 70) ntime = $urandom_range(0, 50);
      send_request(REQ_SET, SlotIdW'($urandom), $urandom, ntime);
    end
  endtask

  // Stimulus and verdict
  initial begin
    int unsigned n;
    int unsigned tail;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    items_sent      = 0;
    req_ch.valid    = 1'b0;
    req_ch.req_type = REQ_TICK;
    req_ch.slot_id  = '0;
    req_ch.interval = '0;
    req_ch.new_time = '0;
    rst_ni          = 1'b0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: empty tick, bad-interval, ok and exists adds, fires, wrap of counter and expiry
    send_request(REQ_TICK, 4'd0,  32'd0, 32'd0);
    send_request(REQ_ADD,  4'd0,  32'd0, 32'd0);
    send_request(REQ_ADD,  4'd0,  32'd1, 32'd0);
    send_request(REQ_ADD,  4'd0,  32'd7, 32'd0);
    send_request(REQ_ADD,  4'd15, 32'd2, 32'hFFFF_FFFF);
    send_request(REQ_ADD,  4'd9,  32'hFFFF_FFFF, 32'd0);
    send_request(REQ_DEL,  4'd3,  32'd0, 32'd0);
    send_request(REQ_TICK, 4'd0,  32'd0, 32'd0);
    send_request(REQ_TICK, 4'd0,  32'd0, 32'd0);
    send_request(REQ_SET,  4'd0,  32'd0, 32'hFFFF_FFF0);
    send_request(REQ_ADD,  4'd7,  32'h20, 32'd0);
    send_request(REQ_TICK, 4'd0,  32'd0, 32'd0);
    send_request(REQ_SET,  4'd0,  32'd0, 32'hFFFF_FFFF);
    send_request(REQ_TICK, 4'd0,  32'd0, 32'd0);
    send_request(REQ_DEL,  4'd0,  32'd0, 32'd0);
    send_request(REQ_DEL,  4'd15, 32'd0, 32'd0);
    send_request(REQ_DEL,  4'd9,  32'd0, 32'd0);
    send_request(REQ_DEL,  4'd7,  32'd0, 32'd0);
    send_request(REQ_DEL,  4'd7,  32'd0, 32'd0);
    send_request(REQ_TICK, 4'd0,  32'd0, 32'd0);
    send_request(REQ_SET,  4'd0,  32'd0, 32'd0);
    send_request(REQ_ADD,  4'd10, 32'h8000_0000, 32'd0);
    send_request(REQ_DEL,  4'd10, 32'd0, 32'd0);

    // Random phases, each under its own idle mix
    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = send_idle_tab[p];
      recv_stall_pct = recv_stall_tab[p];
      n = 0;
      while (n < 120) begin
        if ($urandom_range(99) < 4) begin
          // fill the table with short periods so ticks fire many slots
          for (int s = 0; s < SlotsDefault; s++)
            send_request(REQ_ADD, SlotIdW'(s), $urandom_range(1, 3), $urandom);
          repeat (3) send_request(REQ_TICK, 4'd0, $urandom, $urandom);
          n += SlotsDefault + 3;
        end else begin
          random_request();
          n++;
        end
      end
    end
    req_ch.valid <= 1'b0;
    recv_stall_pct = 0;

    // Drain, then let any stray result show up
    while (pending != 0) @(negedge clk_i);
    for (tail = 0; tail < 48; tail++) @(negedge clk_i);

    $display("covered %0d requests over four gap/stall mixes", items_sent);
    $display("checked %0d results, %0d of them slot fires", result_count, fire_count);
    if (fail_count == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
